// ===== rtl/dotted_quad_ipv4_parser_unit_defines.svh =====
// assertion macros shared by the rtl
`ifndef DOTTED_QUAD_IPV4_PARSER_UNIT_DEFINES_SVH
`define DOTTED_QUAD_IPV4_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DQIP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dqip same-cycle check failed");

// next-cycle implication, checked out of reset
`define DQIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dqip next-cycle check failed");

`endif

// ===== rtl/dqip_pkg.sv =====
`default_nettype none

package dqip_pkg;

    // field widths
    localparam int unsigned CHAR_W  = 16;
    localparam int unsigned OCTET_W = 8;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned DOTS_W  = 2;

    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [OCTET_W-1:0] t_octet;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [DOTS_W-1:0]  t_dots;

    // product of one octet step: 255 * 10 + 9 fits in 12 bits
    typedef logic [11:0] t_wide_octet;

    // character codes
    localparam t_char CHAR_ZERO = 16'h0030;
    localparam t_char CHAR_NINE = 16'h0039;
    localparam t_char CHAR_DOT  = 16'h002E;

    localparam t_wide_octet OCTET_MAX = 12'd255;
    localparam t_wide_octet RADIX     = 12'd10;
    localparam t_dots       DOTS_FULL = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/dotted_quad_ipv4_parser_unit.sv =====
`default_nettype none

// Parses a dotted-quad IPv4 address sent as UTF-16 characters, one character
// per transfer on the slave stream, with tlast set on a closing transfer that
// carries no character. Each closing transfer yields one result transfer on
// the master stream: the 32-bit address (first octet in the top byte, zero
// when the text is invalid), a text-valid flag and a subnet-mask flag.
// Characters are taken at one per clock with no gaps; the parse state is a
// single register stage updated by one multiply-by-ten, add and compare per
// character, so the sustained rate is one transfer per cycle unless stalled.
// The end marker is held in the input register, its result in the result
// register. The slave side keeps accepting characters while a result waits
// on the master side; only a second end marker stalls behind an untaken result.
`include "dotted_quad_ipv4_parser_unit_defines.svh"

module dotted_quad_ipv4_parser_unit
    import dqip_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // [15:0] char_code
    input  wire logic        i_s_axis_tlast,  // end_of_text
    // master stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,  // [31:0] address
    output logic [1:0]       o_m_axis_tuser   // [0] text_valid, [1] mask_valid
);

    // input register
    logic  r_in_valid;
    t_char r_in_char;
    logic  r_in_last;

    // parse state
    t_octet             r_octet;
    t_dots              r_dots;
    logic [3*OCTET_W-1:0] r_done;
    logic               r_error;
    logic               r_char_seen;

    t_octet             n_octet;
    t_dots              n_dots;
    logic [3*OCTET_W-1:0] n_done;
    logic               n_error;
    logic               n_char_seen;

    // result register
    logic  r_out_valid;
    t_addr r_out_addr;
    logic  r_out_text_valid;
    logic  r_out_mask_valid;

    logic        s_in_xfer;
    logic        s_step;
    logic        s_is_digit;
    logic        s_is_dot;
    t_wide_octet s_next_octet;
    logic        s_text_valid;
    t_addr       s_addr;
    t_addr       s_inv;
    logic        s_mask_valid;

    // the held item moves on unless it is an end marker blocked by a waiting result
    assign s_step          = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || s_step;
    assign s_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;

    // character classes and octet arithmetic
    assign s_is_digit   = (r_in_char >= CHAR_ZERO) && (r_in_char <= CHAR_NINE);
    assign s_is_dot     = (r_in_char == CHAR_DOT);
    assign s_next_octet = {4'b0000, r_octet} * RADIX + {8'h00, r_in_char[3:0]};

    // result of the text closed by the held end marker
    assign s_text_valid = !r_error && r_char_seen && (r_dots == DOTS_FULL);
    assign s_addr       = s_text_valid ? {r_done, r_octet} : '0;
    assign s_inv        = ~s_addr;
    assign s_mask_valid = s_text_valid && ((s_inv & (s_inv + 32'd1)) == '0);

    // next parse state
    always_comb begin
        n_octet     = r_octet;
        n_dots      = r_dots;
        n_done      = r_done;
        n_error     = r_error;
        n_char_seen = r_char_seen;
        if (s_step) begin
            if (r_in_last) begin
                n_octet     = '0;
                n_dots      = '0;
                n_done      = '0;
                n_error     = 1'b0;
                n_char_seen = 1'b0;
            end else begin
                n_char_seen = 1'b1;
                if (!r_error) begin
                    priority if (s_is_digit) begin
                        if (s_next_octet > OCTET_MAX) begin
                            n_error = 1'b1;
                        end else begin
                            n_octet = s_next_octet[OCTET_W-1:0];
                        end
                    end else if (s_is_dot) begin
                        if (r_dots == DOTS_FULL) begin
                            n_error = 1'b1;
                        end else begin
                            n_done  = {r_done[2*OCTET_W-1:0], r_octet};
                            n_octet = '0;
                            n_dots  = r_dots + 2'd1;
                        end
                    end else begin
                        n_error = 1'b1;
                    end
                end
            end
        end
    end

    // control and parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_octet     <= '0;
            r_dots      <= '0;
            r_done      <= '0;
            r_error     <= 1'b0;
            r_char_seen <= 1'b0;
        end else begin
            if (s_in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (s_step) begin
                r_in_valid <= 1'b0;
            end
            if (s_step && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_octet     <= n_octet;
            r_dots      <= n_dots;
            r_done      <= n_done;
            r_error     <= n_error;
            r_char_seen <= n_char_seen;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_in_xfer) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (s_step && r_in_last) begin
            r_out_addr       <= s_addr;
            r_out_text_valid <= s_text_valid;
            r_out_mask_valid <= s_mask_valid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_addr;
    assign o_m_axis_tuser  = {r_out_mask_valid, r_out_text_valid};

    // checks
    `DQIP_ASSERT_IMP(a_invalid_is_zero, i_clk, i_rst_n, r_out_valid && !r_out_text_valid, r_out_addr == '0 && !r_out_mask_valid)
    `DQIP_ASSERT_IMP(a_mask_needs_text, i_clk, i_rst_n, r_out_valid && r_out_mask_valid, r_out_text_valid)
    `DQIP_ASSERT_NEXT(a_end_clears_state, i_clk, i_rst_n, s_step && r_in_last, r_dots == '0 && !r_error && !r_char_seen && r_octet == '0)
    `DQIP_ASSERT_IMP(a_stall_only_when_held, i_clk, i_rst_n, !o_s_axis_tready, r_in_valid && r_in_last && r_out_valid)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb
    import dqip_pkg::*;
;

    // one expected result transfer
    typedef struct packed {
        t_addr addr;
        logic  text_ok;
        logic  mask_ok;
    } t_parse_result;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_LONG_HOLD
    } t_rx_mode;

    localparam int unsigned RANDOM_ITEMS = 850;
    localparam int unsigned DRAIN_CYCLES = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [15:0] s_data = '0;
    logic        s_last = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;
    logic [1:0]  m_user;

    // parse state mirrored from the block
    t_octet      acc_octet;
    t_dots       dots_taken;
    logic [23:0] prior_octets;
    logic        text_bad;
    logic        seen_char;

    t_parse_result expected_results[$];
    int unsigned   items_sent;
    int unsigned   burst_left;
    int unsigned   err_count = 0;
    int unsigned   rx_cycle = 0;
    t_rx_mode      rx_mode = RX_ALWAYS;

    dotted_quad_ipv4_parser_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [15:0] char_code
        .i_s_axis_tlast  (s_last),   // end_of_text
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [31:0] address
        .o_m_axis_tuser  (m_user)    // [0] text_valid, [1] mask_valid
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predict the effect of one accepted transfer
    function automatic void track_item(input t_char c, input logic last);
        int unsigned   grown;
        t_parse_result res;
        t_addr         inv;
        if (!last) begin
            seen_char = 1'b1;
            if (!text_bad) begin
                if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                    grown = int'(acc_octet) * int'(RADIX) + int'(c - CHAR_ZERO);
                    if (grown > int'(OCTET_MAX))
                        text_bad = 1'b1;
                    else
                        acc_octet = t_octet'(grown);
                end else if (c == CHAR_DOT) begin
                    if (dots_taken == DOTS_FULL) begin
                        text_bad = 1'b1;
                    end else begin
                        prior_octets = {prior_octets[15:0], acc_octet};
                        acc_octet    = '0;
                        dots_taken   = dots_taken + 2'd1;
                    end
                end else begin
                    text_bad = 1'b1;
                end
            end
        end else begin
            res = '0;
            if (!text_bad && seen_char && dots_taken == DOTS_FULL) begin
                res.addr    = {prior_octets, acc_octet};
                res.text_ok = 1'b1;
                inv         = ~res.addr;
                res.mask_ok = ((inv & (inv + 32'd1)) == '0);
            end
            expected_results.push_back(res);
            acc_octet    = '0;
            dots_taken   = '0;
            prior_octets = '0;
            text_bad     = 1'b0;
            seen_char    = 1'b0;
        end
    endfunction

    // decimal digits of value, with optional leading zeros
    function automatic void push_decimal(ref t_char txt[$], input int unsigned value,
                                         input int unsigned zeros);
        t_char       digits[$];
        int unsigned v;
        v = value;
        repeat (zeros) txt.push_back(CHAR_ZERO);
        do begin
            digits.push_front(CHAR_ZERO + t_char'(v % int'(RADIX)));
            v = v / int'(RADIX);
        end while (v != 0);
        foreach (digits[k]) txt.push_back(digits[k]);
    endfunction

    // character from a pool biased toward the interesting codes
    function automatic t_char random_char();
        t_char c;
        case ($urandom_range(0, 5))
            0: c = CHAR_ZERO + t_char'($urandom_range(0, 9));
            1: c = CHAR_DOT;
            2: c = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
            3: c = $urandom_range(0, 1) ? CHAR_ZERO - 16'd1 : CHAR_NINE + 16'd1;
            4: c = t_char'($urandom);
            default: c = (CHAR_ZERO + t_char'($urandom_range(0, 9)))
                         | t_char'($urandom_range(1, 255) << 8);
        endcase
        return c;
    endfunction

    // well-formed dotted quad with random content
    function automatic void build_quad(ref t_char txt[$]);
        t_addr       a;
        t_octet      octet;
        int unsigned n;
        case ($urandom_range(0, 2))
            0: begin
                n = $urandom_range(0, 32);
                a = (n == 0) ? '0 : (32'hFFFF_FFFF << (32 - n));
            end
            1: a = $urandom;
            default: begin
                for (int i = 0; i < 4; i++) begin
                    case ($urandom_range(0, 2))
                        0: a[i*8 +: 8] = 8'h00;
                        1: a[i*8 +: 8] = 8'hFF;
                        default: a[i*8 +: 8] = t_octet'($urandom);
                    endcase
                end
            end
        endcase
        for (int i = 3; i >= 0; i--) begin
            octet = a[i*8 +: 8];
            if (!(octet == '0 && $urandom_range(0, 4) == 0))
                push_decimal(txt, 32'(octet),
                             ($urandom_range(0, 6) == 0) ? $urandom_range(1, 2) : 0);
            if (i != 0)
                txt.push_back(CHAR_DOT);
        end
    endfunction

    // one transfer on the slave side, with bursts and gaps
    task automatic send_item(input t_char c, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            s_valid <= 1'b0;
            s_data  <= t_char'($urandom);
            s_last  <= 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data  <= c;
        s_last  <= last;
        do @(posedge i_clk); while (!s_ready);
        track_item(c, last);
        items_sent++;
        burst_left--;
    endtask

    // characters of one text, then the end marker
    task automatic send_text(input t_char txt[$], input t_char end_data);
        foreach (txt[k]) send_item(txt[k], 1'b0);
        send_item(end_data, 1'b1);
    endtask

    // empty text and empty octets
    task automatic test_empty_octets();
        t_char txt[$];
        send_text(txt, 16'hFFFF);
        txt = {CHAR_DOT, CHAR_DOT, CHAR_DOT};
        send_text(txt, 16'h0000);
        txt = {CHAR_DOT, CHAR_DOT, CHAR_DOT, CHAR_DOT};
        send_text(txt, CHAR_DOT);
    endtask

    // octet at the top of its range and just above it
    task automatic test_octet_range();
        t_char txt[$];
        push_decimal(txt, 255, 0);
        txt.push_back(CHAR_DOT);
        txt.push_back(CHAR_DOT);
        txt.push_back(CHAR_DOT);
        send_text(txt, CHAR_NINE);
        txt.delete();
        push_decimal(txt, 256, 0);
        send_text(txt, CHAR_ZERO);
    endtask

    // codes outside digits and dot, then characters after an error
    task automatic test_bad_chars();
        t_char txt[$];
        txt = {16'hFFFF, CHAR_ZERO + 16'd1};
        send_text(txt, 16'hFFFF);
        txt = {16'h0000, CHAR_DOT};
        send_text(txt, 16'h0000);
    endtask

    // mostly well-formed quads, the rest mutated or garbage
    task automatic test_random_texts();
        t_char       txt[$];
        int unsigned first_item;
        int unsigned len;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            txt.delete();
            build_quad(txt);
            case ($urandom_range(0, 9))
                7: txt.insert($urandom_range(0, txt.size()), random_char());
                8: begin
                    if ($urandom_range(0, 1))
                        txt.insert($urandom_range(0, txt.size()), CHAR_DOT);
                    else if (txt.size() > 0)
                        txt.delete($urandom_range(0, txt.size() - 1));
                end
                9: begin
                    if ($urandom_range(0, 1)) begin
                        // extra digits, usually pushing an octet past its range
                        repeat ($urandom_range(1, 3))
                            txt.insert($urandom_range(0, txt.size()),
                                       CHAR_ZERO + t_char'($urandom_range(0, 9)));
                    end else begin
                        txt.delete();
                        len = $urandom_range(0, 10);
                        repeat (len) txt.push_back(random_char());
                    end
                end
                default: ;
            endcase
            send_text(txt, t_char'($urandom));
        end
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 128 == 0)
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_ALWAYS:      m_ready <= 1'b1;
            RX_COIN:        m_ready <= 1'($urandom_range(0, 1));
            RX_ONE_IN_FOUR: m_ready <= (rx_cycle % 4 == 0);
            default:        m_ready <= (rx_cycle % 32 >= 24);
        endcase
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_parse_result exp_res;
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: address %h user %b", m_data, m_user);
                err_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (m_data !== exp_res.addr) begin
                    $error("address: expected %h, actual %h", exp_res.addr, m_data);
                    err_count++;
                end
                if (m_user[0] !== exp_res.text_ok) begin
                    $error("text_valid: expected %b, actual %b", exp_res.text_ok, m_user[0]);
                    err_count++;
                end
                if (m_user[1] !== exp_res.mask_ok) begin
                    $error("mask_valid: expected %b, actual %b", exp_res.mask_ok, m_user[1]);
                    err_count++;
                end
            end
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // sequence of tests
    initial begin
        acc_octet    = '0;
        dots_taken   = '0;
        prior_octets = '0;
        text_bad     = 1'b0;
        seen_char    = 1'b0;
        items_sent   = 0;
        burst_left   = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_octets();
        test_octet_range();
        test_bad_chars();
        test_random_texts();

        @(negedge i_clk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && expected_results.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dqip_pkg.sv
rtl/dotted_quad_ipv4_parser_unit.sv
bench/tb.sv
